// ===== src/console_line_editor_top_defines.svh =====
// assertion macros for the console line editor top level
// expects clk and rst_n in the scope of each use
`ifndef CONSOLE_LINE_EDITOR_TOP_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_TOP_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define CLE_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("console line editor check failed");

// condition holds in the cycle after the trigger
`define CLE_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("console line editor check failed");

`endif

// ===== src/cle_pkg.sv =====
// shared types, character codes and key decode functions of the console line editor
// no dependencies
`default_nettype none

package cle_pkg;

  // parameter defaults
  localparam int BUFFER_DEPTH_DEF = 128;
  localparam int READ_LIMIT_DEF   = 32;
  localparam int ESCAPE_LIMIT_DEF = 8;
  localparam int MAX_RESULTS      = 32;

  // character codes
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_NL        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_DEL       = 8'h7F;
  localparam logic [7:0] CH_BEL       = 8'h07;
  localparam logic [7:0] CH_CTRL_D    = 8'h04;
  localparam logic [7:0] CH_CTRL_N    = 8'h0E;
  localparam logic [7:0] CH_CTRL_P    = 8'h10;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_UPPER_O   = 8'h4F;
  localparam logic [7:0] CH_LOWER_C   = 8'h63;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_GT        = 8'h3E;

  // result kinds
  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [7:0] key_byte;
    logic [5:0] read_max;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       last;
    logic       read_empty;
    logic       buffer_full;
    logic       line_ready;
    logic       dump_request;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       fetch;
    logic       exec;
    logic       rfetch;
    logic       emit_q;
    logic       emit_rd;
    logic [1:0] step_idx;
  } cle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       rd_go;
    logic [1:0] nsteps;
    logic       q_empty;
    logic       q_last;
    logic       rd_last;
    logic       out_free;
  } cle_stat_t;

  // number of editing steps a key byte runs
  function automatic logic [1:0] key_steps(input logic [7:0] key);
    logic [1:0] n;
    n = 2'd0;
    if (key == CH_ESC) begin
      n = 2'd1;
    end else if (key == CH_DEL) begin
      n = 2'd3;
    end else if (key == CH_CR || key == CH_NL) begin
      n = 2'd1;
    end else if (key >= CH_SPACE && key <= CH_TILDE) begin
      n = 2'd1;
    end else if (key == CH_CTRL_D) begin
      n = 2'd1;
    end
    return n;
  endfunction

  // character handled by one editing step
  function automatic logic [7:0] step_char(input logic [7:0] key, input logic [1:0] idx);
    logic [7:0] ch;
    ch = key;
    if (key == CH_DEL) begin
      ch = (idx == 2'd1) ? CH_SPACE : CH_BS;
    end else if (key == CH_CR || key == CH_NL) begin
      ch = CH_NL;
    end
    return ch;
  endfunction

  // bytes that close an escape sequence
  function automatic logic ends_escape(input logic [7:0] ch);
    logic letter;
    letter = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    return (ch == CH_TILDE) || (ch == CH_BEL) || (ch == CH_BACKSLASH) ||
           ((ch != CH_UPPER_O) && letter);
  endfunction

endpackage

`default_nettype wire

// ===== src/console_line_editor_top.sv =====
// Console line editor. One beat in is a key byte (req_type 0) or a read request
// (req_type 1); each input yields one or more result beats, the final one with
// last set. Flags are the same on every beat of one input.
// Key bytes: each editing step is a fetch of the newest stored byte, then an
// execute; one step for most keys and three for DEL, then echo beats drain at
// one per cycle while out_stall allows; a key with no editing step gives one
// status-only beat, but Ctrl-N gives four echo beats with no editing steps.
// Reads: each data byte is a registered read of the line store, then the output
// register; up to min(read_max, READ_LIMIT, MAX_RESULTS) bytes, fewer if the line runs out.
// Only one input is worked on at a time; in_stall is low only between inputs,
// and the next input can be taken while the last result beat still waits.
// Reset (rst_n low, synchronous) empties the ring and leaves discard mode; the
// line store itself needs no clearing. When out_stall is high the pending beat
// holds and the editor waits before producing the next one.
// depends on cle_pkg, cle_ctrl, cle_datapath and the defines header
`default_nettype none
`include "console_line_editor_top_defines.svh"

module console_line_editor_top #(
  parameter int BUFFER_DEPTH = cle_pkg::BUFFER_DEPTH_DEF,
  parameter int READ_LIMIT   = cle_pkg::READ_LIMIT_DEF,
  parameter int ESCAPE_LIMIT = cle_pkg::ESCAPE_LIMIT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  cle_pkg::in_item_t      in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cle_pkg::out_item_t     out_data
);

  cle_pkg::cle_cmd_t  cmd;
  cle_pkg::cle_stat_t stat;

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cle_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .READ_LIMIT   (READ_LIMIT),
    .ESCAPE_LIMIT (ESCAPE_LIMIT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // an accepted input always makes the controller busy in the next cycle
  `CLE_ASSERT_NEXT(a_accept_goes_busy, in_valid && !in_stall, in_stall)
  // a stalled result beat stays valid and unchanged
  `CLE_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(out_data))
  // read data beats never carry the empty or full flags
  `CLE_ASSERT_SAME(a_read_flags_clean, out_valid && (out_data.out_kind == cle_pkg::KIND_READ),
                   !out_data.read_empty && !out_data.buffer_full)

endmodule

`default_nettype wire

// ===== src/cle_ctrl.sv =====
// sequencing state machine of the console line editor
// depends on cle_pkg for the command and status structs
`default_nettype none

module cle_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  cle_pkg::cle_stat_t     stat,
  output cle_pkg::cle_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FETCH  = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_RFETCH = 3'd4;
  localparam logic [2:0] ST_RSEND  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] nsteps_r, nsteps_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    nsteps_nxt   = nsteps_r;
    cmd          = '0;
    cmd.step_idx = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          idx_nxt  = 2'd0;
          if (stat.rd_go) begin
            state_nxt = ST_RFETCH;
          end else if (stat.nsteps != 2'd0) begin
            nsteps_nxt = stat.nsteps;
            state_nxt  = ST_FETCH;
          end else begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (idx_r == nsteps_r - 2'd1) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_FETCH;
        end
      end
      ST_DRAIN: begin
        if (stat.out_free) begin
          cmd.emit_q = 1'b1;
          if (stat.q_empty || stat.q_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RFETCH: begin
        cmd.rfetch = 1'b1;
        state_nxt  = ST_RSEND;
      end
      ST_RSEND: begin
        if (stat.out_free) begin
          cmd.emit_rd = 1'b1;
          state_nxt   = stat.rd_last ? ST_IDLE : ST_RFETCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= 2'd0;
      nsteps_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      nsteps_r <= nsteps_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/cle_datapath.sv =====
// line store, ring indices, escape tracking, echo queue and output register
// depends on cle_pkg; driven by cle_ctrl commands
`default_nettype none

module cle_datapath #(
  parameter int BUFFER_DEPTH = cle_pkg::BUFFER_DEPTH_DEF,
  parameter int READ_LIMIT   = cle_pkg::READ_LIMIT_DEF,
  parameter int ESCAPE_LIMIT = cle_pkg::ESCAPE_LIMIT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  cle_pkg::in_item_t      in_data,
  input  cle_pkg::cle_cmd_t      cmd,
  output cle_pkg::cle_stat_t     stat,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cle_pkg::out_item_t     out_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(ESCAPE_LIMIT + 1);
  localparam int RL = (READ_LIMIT < cle_pkg::MAX_RESULTS) ? READ_LIMIT : cle_pkg::MAX_RESULTS;
  localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);

  logic [7:0]    line_store [BUFFER_DEPTH];
  logic [7:0]    rdata_r;

  logic [AW-1:0] w_r, w_nxt;
  logic [AW-1:0] r_r, r_nxt;
  logic          esc_r, esc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          full_r, full_nxt;
  logic [2:0]    q_cnt_r, q_cnt_nxt;
  logic [1:0]    q_ptr_r;
  logic [7:0]    q_byte_r [4];

  logic [7:0]    key_r;
  logic          line_r, dump_r, empty_r;
  logic [5:0]    lim_r, n_r;
  logic          rd_last_r;

  logic                 out_valid_r;
  cle_pkg::out_item_t   out_r;

  logic [AW-1:0] prev_w, next_w, next_r;
  logic          buf_empty;
  logic [7:0]    ch;
  logic [CW-1:0] cnt_inc;
  logic          push, we;
  logic [5:0]    lim_in;
  logic [5:0]    n_inc;
  logic          out_free;
  logic          clear_key;

  // ring index arithmetic
  assign prev_w    = (w_r == '0) ? LAST_IDX : w_r - 1'b1;
  assign next_w    = (w_r == LAST_IDX) ? '0 : w_r + 1'b1;
  assign next_r    = (r_r == LAST_IDX) ? '0 : r_r + 1'b1;
  assign buf_empty = (w_r == r_r);
  assign ch        = cle_pkg::step_char(key_r, cmd.step_idx);
  assign cnt_inc   = cnt_r + 1'b1;
  assign n_inc     = n_r + 6'd1;
  assign lim_in    = (in_data.read_max > 6'(RL)) ? 6'(RL) : in_data.read_max;
  assign out_free  = !out_valid_r || !out_stall;
  assign clear_key = !in_data.req_type && (in_data.key_byte == cle_pkg::CH_CTRL_N);

  // status to the controller
  assign stat.rd_go    = in_data.req_type && !buf_empty && (lim_in != 6'd0);
  assign stat.nsteps   = in_data.req_type ? 2'd0 : cle_pkg::key_steps(in_data.key_byte);
  assign stat.q_empty  = (q_cnt_r == 3'd0);
  assign stat.q_last   = (3'(q_ptr_r) + 3'd1 == q_cnt_r);
  assign stat.rd_last  = rd_last_r;
  assign stat.out_free = out_free;

  // one editing step, load and read pointer updates
  always_comb begin
    w_nxt     = w_r;
    r_nxt     = r_r;
    esc_nxt   = esc_r;
    cnt_nxt   = cnt_r;
    full_nxt  = full_r;
    q_cnt_nxt = q_cnt_r;
    push      = 1'b0;
    we        = 1'b0;
    if (cmd.load) begin
      full_nxt  = 1'b0;
      q_cnt_nxt = 3'd0;
      if (clear_key) begin
        w_nxt     = '0;
        r_nxt     = '0;
        esc_nxt   = 1'b0;
        cnt_nxt   = '0;
        q_cnt_nxt = 3'd4;
      end
    end
    if (cmd.exec) begin
      if (esc_r) begin
        // discard mode swallows the byte
        if (cle_pkg::ends_escape(ch) || (cnt_inc >= CW'(ESCAPE_LIMIT))) begin
          esc_nxt = 1'b0;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end else if (ch == cle_pkg::CH_BS) begin
        // never erase past a newline or an empty buffer
        if (!buf_empty && (rdata_r != cle_pkg::CH_NL)) begin
          w_nxt = prev_w;
          push  = 1'b1;
        end
      end else if (ch == cle_pkg::CH_ESC) begin
        esc_nxt = 1'b1;
        cnt_nxt = CW'(1);
      end else if (next_w == r_r) begin
        full_nxt = 1'b1;
      end else begin
        we    = 1'b1;
        w_nxt = next_w;
        push  = 1'b1;
      end
      if (push) begin
        q_cnt_nxt = q_cnt_r + 3'd1;
      end
    end
    if (cmd.rfetch) begin
      r_nxt = next_r;
    end
  end

  // line store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      line_store[w_r] <= ch;
    end
    if (cmd.fetch) begin
      rdata_r <= line_store[prev_w];
    end else if (cmd.rfetch) begin
      rdata_r <= line_store[r_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= '0;
      r_r         <= '0;
      esc_r       <= 1'b0;
      cnt_r       <= '0;
      q_cnt_r     <= 3'd0;
      q_ptr_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      w_r     <= w_nxt;
      r_r     <= r_nxt;
      esc_r   <= esc_nxt;
      cnt_r   <= cnt_nxt;
      q_cnt_r <= q_cnt_nxt;
      if (cmd.load) begin
        q_ptr_r <= 2'd0;
      end else if (cmd.emit_q) begin
        q_ptr_r <= q_ptr_r + 2'd1;
      end
      if (cmd.emit_q || cmd.emit_rd) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item fields, echo queue and output beat
  always_ff @(posedge clk) begin
    full_r <= full_nxt;
    if (cmd.load) begin
      key_r   <= in_data.key_byte;
      line_r  <= !in_data.req_type && ((in_data.key_byte == cle_pkg::CH_CR) ||
                 (in_data.key_byte == cle_pkg::CH_NL) ||
                 (in_data.key_byte == cle_pkg::CH_CTRL_D));
      dump_r  <= !in_data.req_type && (in_data.key_byte == cle_pkg::CH_CTRL_P);
      empty_r <= in_data.req_type && buf_empty;
      lim_r   <= lim_in;
      n_r     <= 6'd0;
      if (clear_key) begin
        q_byte_r[0] <= cle_pkg::CH_ESC;
        q_byte_r[1] <= cle_pkg::CH_LOWER_C;
        q_byte_r[2] <= cle_pkg::CH_DOLLAR;
        q_byte_r[3] <= cle_pkg::CH_GT;
      end
    end
    if (push) begin
      q_byte_r[q_cnt_r[1:0]] <= ch;
    end
    if (cmd.rfetch) begin
      n_r       <= n_inc;
      rd_last_r <= (n_inc == lim_r) || (next_r == w_r);
    end
    if (cmd.emit_q) begin
      out_r.out_kind <= stat.q_empty ? cle_pkg::KIND_STATUS : cle_pkg::KIND_ECHO;
      out_r.out_byte <= stat.q_empty ? 8'h00 : q_byte_r[q_ptr_r];
      out_r.last     <= stat.q_empty || stat.q_last;
    end else if (cmd.emit_rd) begin
      out_r.out_kind <= cle_pkg::KIND_READ;
      out_r.out_byte <= rdata_r;
      out_r.last     <= rd_last_r;
    end
    if (cmd.emit_q || cmd.emit_rd) begin
      out_r.read_empty   <= empty_r;
      out_r.buffer_full  <= full_r;
      out_r.line_ready   <= line_r;
      out_r.dump_request <= dump_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
